// File: hdl/text_console_cursor_engine_top_defines.svh
// Assertion macros for the text console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tcce_pkg.sv
// Shared types and constants of the text console cursor engine.
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;
  localparam int CURSOR_POS_W    = 11;
  localparam int TAB_STEP        = 8;

  localparam logic [1:0] KIND_PRINT = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] BLANK_CELL  = 16'h0720;
  localparam logic [7:0]  COLOR_RESET = 8'h07;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] cell_x;
    logic [4:0] cell_y;
  } tcce_item_t;

  typedef struct packed {
    logic [CURSOR_POS_W-1:0] cursor_pos;
    logic [15:0]             cell_entry;
    logic                    scrolled;
  } tcce_result_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic clear_step;
    logic copy_step;
    logic blank_step;
    logic cnt_clear;
    logic load_result;
  } tcce_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scroll_needed;
    logic copy_done;
    logic blank_done;
  } tcce_stat_t;

endpackage
`default_nettype wire

// File: hdl/tcce_ctrl.sv
// Controller state machine of the text console cursor engine.
`timescale 1ns / 1ps
`default_nettype none
module tcce_ctrl import tcce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  output logic            result_valid,
  input  wire logic       result_ready,
  input  wire tcce_stat_t stat,
  output tcce_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_BLANK,
    S_RESP
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   result_valid_next;

  assign out_free = !result_valid || result_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.cnt_clear = 1'b1;
        state_next    = stat.scroll_needed ? S_COPY : S_RESP;
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_done) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (stat.blank_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          item_ready      = 1'b1;
          if (item_valid) begin
            cmd.load_item = 1'b1;
            state_next    = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_result) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tcce_datapath.sv
// Datapath of the text console cursor engine: cursor, screen memory and result register.
`timescale 1ns / 1ps
`default_nettype none
module tcce_datapath import tcce_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire tcce_item_t item,
  input  wire tcce_cmd_t  cmd,
  output tcce_stat_t      stat,
  output tcce_result_t    result
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  tcce_item_t       item_q;
  logic [7:0]       text_color;
  logic [ROW_W-1:0] row, row_next, sel_row;
  logic [COL_W-1:0] col, col_next, sel_col;
  logic [COL_W:0]   col_inc, col_tab;
  logic             last_row, in_range, new_line;
  logic             ex_we, ex_re, read_ok, read_ok_next, scroll_flag;
  logic [15:0]      ex_wdata;
  logic [ADDR_W-1:0] ex_addr;
  logic [CNT_W-1:0] cnt;

  logic [15:0]       cells [CELLS];
  logic [15:0]       rdata, wdata;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              we, re;

  assign col_inc  = {1'b0, col} + (COL_W+1)'(1);
  assign col_tab  = ({1'b0, col} + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
  assign last_row = (row == ROW_W'(ROWS - 1));
  assign in_range = (32'(item_q.cell_x) < COLUMNS) && (32'(item_q.cell_y) < ROWS);

  always_comb begin
    row_next     = row;
    col_next     = col;
    sel_row      = row;
    sel_col      = col;
    new_line     = 1'b0;
    ex_we        = 1'b0;
    ex_re        = 1'b0;
    read_ok_next = 1'b0;
    ex_wdata     = {text_color, item_q.char_code};
    case (item_q.kind)
      KIND_PRINT: begin
        case (item_q.char_code)
          CH_LF: begin
            new_line = 1'b1;
          end
          CH_CR: begin
            col_next = '0;
          end
          CH_TAB: begin
            if (32'(col_tab) >= COLUMNS) begin
              new_line = 1'b1;
            end else begin
              col_next = COL_W'(col_tab);
            end
          end
          CH_BS: begin
            ex_wdata = {text_color, CH_SPACE};
            if (col != '0) begin
              col_next = col - COL_W'(1);
              sel_col  = col - COL_W'(1);
              ex_we    = 1'b1;
            end else if (row != '0) begin
              row_next = row - ROW_W'(1);
              col_next = COL_W'(COLUMNS - 1);
              sel_row  = row - ROW_W'(1);
              sel_col  = COL_W'(COLUMNS - 1);
              ex_we    = 1'b1;
            end
          end
          default: begin
            ex_we = 1'b1;
            if (32'(col_inc) >= COLUMNS) begin
              new_line = 1'b1;
            end else begin
              col_next = COL_W'(col_inc);
            end
          end
        endcase
      end
      KIND_WRITE: begin
        sel_row  = ROW_W'(item_q.cell_y);
        sel_col  = COL_W'(item_q.cell_x);
        ex_we    = in_range;
        ex_wdata = {item_q.cell_color, item_q.char_code};
      end
      KIND_READ: begin
        sel_row      = ROW_W'(item_q.cell_y);
        sel_col      = COL_W'(item_q.cell_x);
        ex_re        = 1'b1;
        read_ok_next = in_range;
      end
      default: begin
      end
    endcase
    if (new_line) begin
      col_next = '0;
      if (!last_row) begin
        row_next = row + ROW_W'(1);
      end
    end
  end

  assign ex_addr = ADDR_W'(32'(sel_row) * COLUMNS + 32'(sel_col));

  assign stat.scroll_needed = new_line && last_row;
  assign stat.clear_done    = (cnt == CNT_W'(CELLS - 1));
  assign stat.copy_done     = (cnt == CNT_W'(COPY_N));
  assign stat.blank_done    = (cnt == CNT_W'(COLUMNS - 1));

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = ex_addr;
    raddr = ex_addr;
    wdata = ex_wdata;
    if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = cnt[ADDR_W-1:0];
      wdata = BLANK_CELL;
    end else if (cmd.copy_step) begin
      re    = (cnt < CNT_W'(COPY_N));
      raddr = ADDR_W'(32'(cnt) + COLUMNS);
      we    = (cnt != '0);
      waddr = ADDR_W'(cnt - CNT_W'(1));
      wdata = rdata;
    end else if (cmd.blank_step) begin
      we    = 1'b1;
      waddr = ADDR_W'(32'(cnt) + COPY_N);
      wdata = {text_color, CH_SPACE};
    end else if (cmd.exec) begin
      we = ex_we;
      re = ex_re;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    if (re) begin
      rdata <= cells[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      row        <= '0;
      col        <= '0;
      text_color <= COLOR_RESET;
    end else begin
      if (cmd.cnt_clear) begin
        cnt <= '0;
      end else if (cmd.clear_step || cmd.copy_step || cmd.blank_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.exec) begin
        row <= row_next;
        col <= col_next;
      end
      if (cfg_we) begin
        text_color <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item;
    end
    if (cmd.exec) begin
      read_ok     <= read_ok_next;
      scroll_flag <= stat.scroll_needed;
    end
    if (cmd.load_result) begin
      result.cursor_pos <= CURSOR_POS_W'(32'(row) * COLUMNS + 32'(col));
      result.cell_entry <= read_ok ? rdata : 16'h0000;
      result.scrolled   <= scroll_flag;
    end
  end

endmodule
`default_nettype wire

// File: hdl/text_console_cursor_engine_top.sv
// Top level of the text console cursor engine.
// Each item is taken in, then updates the cursor and touches the screen memory;
// the result is then registered once the output slot is free, and the next item
// is taken in the same cycle. A read returns the cell through the memory's
// registered read port. An item that scrolls first copies the screen up one row
// through that port and then blanks the bottom row. After reset a clearing pass
// over all ROWS*COLUMNS cells fills the screen with blanks while item_ready stays
// low; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_engine_top_defines.svh"
module text_console_cursor_engine_top import tcce_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         item_valid,
  output logic              item_ready,
  input  wire tcce_item_t   item,
  output logic              result_valid,
  input  wire logic         result_ready,
  output tcce_result_t      result
);

  tcce_cmd_t  cmd;
  tcce_stat_t stat;

  tcce_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  tcce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

  `TCCE_ASSERT_NOW(a_no_accept_in_sweep, cmd.copy_step || cmd.blank_step || cmd.clear_step, !item_ready, "item taken during a memory sweep")
  `TCCE_ASSERT_NOW(a_load_needs_slot, cmd.load_result, !result_valid || result_ready, "result overwritten before it was taken")
  `TCCE_ASSERT_NEXT(a_accept_then_exec, item_valid && item_ready, cmd.exec, "accepted item not executed next cycle")
  `TCCE_ASSERT_NOW(a_cursor_in_screen, result_valid, 32'(result.cursor_pos) < ROWS * COLUMNS, "cursor outside the screen")

endmodule
`default_nettype wire
